### design/tes_pkg.sv
`default_nettype none

package tes_pkg;

  // Number of index fields carried by one access word.
  localparam int HW_DIMS  = 4;
  // Largest dimension count that the block accepts.
  localparam int MAX_DIMS = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_STORE_DEPTH   = 4096;
  localparam int DEF_ELEMENT_WIDTH = 32;

  // Fixed field widths.
  localparam int IDX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int DIMS_W     = 3;
  localparam int CNT_W      = 3;
  localparam int WORD_W     = 32;
  localparam int POS_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int STEP_W     = (HW_DIMS > 1) ? $clog2(HW_DIMS) : 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM0_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM1_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM2_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM3_SIZE   = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COUNT = 2'd1,
    ST_INDEX = 2'd2,
    ST_SHAPE = 2'd3
  } tes_status_t;

  // Access word.
  typedef struct packed {
    logic              opcode;
    logic [CNT_W-1:0]  index_count;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [IDX_W-1:0]  index_c;
    logic [IDX_W-1:0]  index_d;
    logic [WORD_W-1:0] write_value;
  } tes_in_t;

  // Result word.
  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic [POS_W-1:0]  linear_position;
    tes_status_t       status;
  } tes_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic access;
    logic finish;
  } tes_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pre_err;
    logic last_step;
  } tes_stat_t;

endpackage

`default_nettype wire

### design/tes_ram.sv
`default_nettype none

module tes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### design/tes_ctrl.sv
`default_nettype none

module tes_ctrl
  import tes_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire tes_stat_t stat,
  output logic           busy,
  output logic           done,
  output tes_cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    ACCESS,
    FINISH
  } state_t;

  state_t state;

  // Commands decoded from the current state.
  always_comb begin
    cmd.load   = (state == IDLE) && start;
    cmd.step   = (state == WALK) && !stat.pre_err;
    cmd.access = (state == ACCESS);
    cmd.finish = (state == FINISH);
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= WALK;
          end
        end
        WALK: begin
          // A rejected access skips the walk and the memory.
          if (stat.pre_err) begin
            state <= FINISH;
          end else if (stat.last_step) begin
            state <= ACCESS;
          end
        end
        ACCESS: begin
          state <= FINISH;
        end
        FINISH: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/tes_datapath.sv
`default_nettype none

module tes_datapath
  import tes_pkg::*;
#(
  parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tes_in_t               request,
  input  wire tes_cmd_t              cmd,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output tes_stat_t                  stat,
  output tes_out_t                   result
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = $clog2(STORE_DEPTH + 1);

  // Configuration registers.
  logic [DIMS_W-1:0] dims;
  logic [SIZE_W-1:0] size [HW_DIMS];

  // Latched access word.
  logic              op;
  logic [WORD_W-1:0] wval;
  logic [IDX_W-1:0]  idx [HW_DIMS];
  tes_status_t       pre_status;

  // Walk state: running product of sizes, running position, overflow mark.
  logic [STEP_W-1:0] step_cnt;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     pos;
  logic              over;

  logic [IDX_W-1:0]        idx_in [HW_DIMS];
  logic                    dims_ok;
  logic                    idx_bad;
  tes_status_t             pre_next;
  logic [PW+SIZE_W-1:0]    prod_full;
  logic [AW+SIZE_W:0]      pos_full;
  tes_status_t             final_status;
  logic                    ok;
  logic                    mem_we;
  logic                    mem_re;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= DIMS_W'(1);
      for (int k = 0; k < HW_DIMS; k++) begin
        size[k] <= SIZE_W'(1);
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIMS_IN_USE: dims    <= cfg_data[DIMS_W-1:0];
        REG_DIM0_SIZE:   size[0] <= cfg_data;
        REG_DIM1_SIZE:   size[1] <= cfg_data;
        REG_DIM2_SIZE:   size[2] <= cfg_data;
        REG_DIM3_SIZE:   size[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign idx_in[0] = request.index_a;
  assign idx_in[1] = request.index_b;
  assign idx_in[2] = request.index_c;
  assign idx_in[3] = request.index_d;

  // Count and range checks on the incoming word, all dimensions side by side.
  always_comb begin
    dims_ok = (int'(dims) >= 1) && (int'(dims) <= HW_DIMS) && (int'(dims) <= MAX_DIMS);
    idx_bad = 1'b0;
    for (int k = 0; k < HW_DIMS; k++) begin
      if ((k < int'(dims)) && ({1'b0, idx_in[k]} >= size[k])) begin
        idx_bad = 1'b1;
      end
    end
    if (!dims_ok || (request.index_count != dims)) begin
      pre_next = ST_COUNT;
    end else if (idx_bad) begin
      pre_next = ST_INDEX;
    end else begin
      pre_next = ST_OK;
    end
  end

  // One multiply-add per walk step for the product and the position.
  assign prod_full = prod * size[step_cnt];
  assign pos_full  = pos * size[step_cnt] + (AW + SIZE_W + 1)'(idx[step_cnt]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= request.opcode;
      wval       <= request.write_value;
      idx        <= idx_in;
      pre_status <= pre_next;
      step_cnt   <= '0;
      prod       <= PW'(1);
      pos        <= '0;
      over       <= 1'b0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + STEP_W'(1);
      prod     <= prod_full[PW-1:0];
      pos      <= pos_full[AW-1:0];
      if (prod_full > (PW + SIZE_W)'(STORE_DEPTH)) begin
        over <= 1'b1;
      end
    end
  end

  assign stat.pre_err   = (pre_status != ST_OK);
  assign stat.last_step = (DIMS_W'(step_cnt) == (dims - DIMS_W'(1)));

  // The position stays below the product, so only the product needs checking.
  assign final_status = ((pre_status == ST_OK) && over) ? ST_SHAPE : pre_status;
  assign ok           = (final_status == ST_OK);

  assign mem_we = cmd.access && ok && op;
  assign mem_re = cmd.access && ok && !op;

  tes_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (pos),
    .wdata (ELEMENT_WIDTH'(wval)),
    .rdata (mem_rdata)
  );

  // Result word register; errors and writes read back as zero.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status          <= final_status;
      result.linear_position <= ok ? POS_W'(pos) : '0;
      result.read_value      <= (ok && !op) ? WORD_W'(mem_rdata) : '0;
    end
  end

endmodule

`default_nettype wire

### design/tensor_element_store.sv
// Channel   Handshake                  Word
// access    start in, busy out         request (tes_in_t)
// result    done strobe out            result (tes_out_t)
// config    cfg_write in               cfg_index, cfg_data
//
// An access is taken when start is high and busy is low. It walks the dimensions
// in use one at a time in the shared multiply-add walk, then visits the element
// memory port and then forms the result; a word rejected by the count or range
// checks skips the walk and the memory. busy stays high until the result is out.
// done is high for one cycle with the result; the receiver cannot stall it.
// Reset is synchronous and clears the controller and the configuration; the
// element memory holds no reset value and needs no clearing pass.
`default_nettype none

module tensor_element_store
  import tes_pkg::*;
#(
  parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
  parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire tes_in_t               request,
  output logic                       done,
  output tes_out_t                   result,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  tes_cmd_t  cmd;
  tes_stat_t stat;

  // Sequencer.
  tes_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Checks, position arithmetic and element memory.
  tes_datapath #(
    .STORE_DEPTH   (STORE_DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

endmodule

`default_nettype wire

### design/tes_checker.sv
`default_nettype none

module tes_checker
  import tes_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire tes_out_t result
);

  // A result word is only shown once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  // An accepted word always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The block only leaves busy by delivering a result.
  a_fall_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy fell without a result");

  // The result strobe is never raised on consecutive cycles.
  a_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe repeated");

  // A failed access reports no position and no data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != ST_OK)) |->
      ((result.linear_position == '0) && (result.read_value == '0)))
    else $error("error result carries data");

endmodule

bind tensor_element_store tes_checker u_checker (.*);

`default_nettype wire
